/* rtl/core/buddy_page_allocator_macros.svh */
// Assertion macros shared by the allocator RTL.
`ifndef BUDDY_PAGE_ALLOCATOR_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_MACROS_SVH

// Check a property at every clock edge outside reset.
`define BPA_CHECK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property at every clock edge, reset included.
`define BPA_CHECK_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* rtl/core/bpa_pkg.sv */
package bpa_pkg;

   // Default geometry
   localparam int PAGE_COUNT_DEF     = 4096;
   localparam int MAX_ORDER_DEF      = 8;
   localparam int PAGE_SIZE_LOG2_DEF = 12;

   // Fixed field widths
   localparam int BYTES_W  = 24;
   localparam int BLOCK_W  = 12;
   localparam int STATUS_W = 3;

   typedef logic [STATUS_W-1:0] status_type;

   // Request kinds
   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   // Result status codes
   localparam status_type ST_OK        = 3'd0;
   localparam status_type ST_TOO_LARGE = 3'd1;
   localparam status_type ST_NO_MEMORY = 3'd2;
   localparam status_type ST_BROKEN    = 3'd3;
   localparam status_type ST_HALTED    = 3'd4;

endpackage

/* rtl/core/bpa_channels.sv */
interface bpa_req_if;
   import bpa_pkg::*;
   logic               valid;
   logic               ready;
   logic               action;
   logic [BYTES_W-1:0] request_bytes;
   logic [BLOCK_W-1:0] freed_block;

   modport source (output valid, action, request_bytes, freed_block, input ready);
   modport sink   (input valid, action, request_bytes, freed_block, output ready);
endinterface

interface bpa_rsp_if;
   import bpa_pkg::*;
   logic               valid;
   logic               ready;
   logic [BLOCK_W-1:0] granted_block;
   status_type         status;

   modport source (output valid, granted_block, status, input ready);
   modport sink   (input valid, granted_block, status, output ready);
endinterface

/* rtl/core/buddy_page_allocator.sv */
// Channel     | Dir | Transaction fields
// req_ch      | in  | action, request_bytes, freed_block
// rsp_ch      | out | granted_block, status
//
// One request at a time. Allocate runs the size search, free-list search and
// splits; free works one merge level at a time on the single-port page table,
// plus one walk step per extra link passed while unlinking a buddy.
// After reset a clearing pass writes every page-table entry with req_ch.ready
// low. A waiting result sits in the output register; the next request is
// taken while it waits, and a finished result stalls until it frees.
`include "buddy_page_allocator_macros.svh"

module buddy_page_allocator
   import bpa_pkg::*;
#(
   parameter int PAGE_COUNT     = PAGE_COUNT_DEF,
   parameter int MAX_ORDER      = MAX_ORDER_DEF,
   parameter int PAGE_SIZE_LOG2 = PAGE_SIZE_LOG2_DEF
) (
   input  logic      clock,
   input  logic      reset,
   bpa_req_if.sink   req_ch,
   bpa_rsp_if.source rsp_ch
);

   localparam int AW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
   localparam int LW = $clog2(PAGE_COUNT + 1);
   localparam int OW = (MAX_ORDER > 0) ? $clog2(MAX_ORDER + 1) : 1;
   localparam int CW = ((LW > MAX_ORDER + 1) ? LW : MAX_ORDER + 1) + 1;
   localparam logic [LW-1:0] NULL_LINK = LW'(PAGE_COUNT);
   localparam logic [CW-1:0] PC_C      = CW'(PAGE_COUNT);
   localparam logic [CW-1:0] TOP_C     = CW'(1) << MAX_ORDER;
   localparam logic [OW-1:0] MAX_O     = OW'(MAX_ORDER);

   localparam logic [4:0] S_INIT  = 5'd0;
   localparam logic [4:0] S_IDLE  = 5'd1;
   localparam logic [4:0] S_SIZE  = 5'd2;
   localparam logic [4:0] S_POP   = 5'd3;
   localparam logic [4:0] S_POPRD = 5'd4;
   localparam logic [4:0] S_SPLIT = 5'd5;
   localparam logic [4:0] S_LAST  = 5'd6;
   localparam logic [4:0] S_FPG   = 5'd7;
   localparam logic [4:0] S_FPGD  = 5'd8;
   localparam logic [4:0] S_FBUDD = 5'd9;
   localparam logic [4:0] S_WALK  = 5'd10;
   localparam logic [4:0] S_WALKD = 5'd11;
   localparam logic [4:0] S_UNL   = 5'd12;
   localparam logic [4:0] S_UNL2  = 5'd13;
   localparam logic [4:0] S_PUSH  = 5'd14;
   localparam logic [4:0] S_DONE  = 5'd15;

   // Page table
   logic [OW-1:0] mem_order [PAGE_COUNT];
   logic          mem_free  [PAGE_COUNT];
   logic [LW-1:0] mem_link  [PAGE_COUNT];
   logic [OW-1:0] rd_order_ff;
   logic          rd_free_ff;
   logic [LW-1:0] rd_link_ff;

   logic [LW-1:0] head_ff [MAX_ORDER+1];

   logic [4:0]         state_ff, state_in;
   logic [AW-1:0]      init_ff, init_in;
   logic [CW-1:0]      pg_ff, pg_in, bud_ff, bud_in;
   logic [LW-1:0]      cur_ff, cur_in, prev_ff, prev_in, steps_ff, steps_in;
   logic [OW-1:0]      ord_ff, ord_in, lvl_ff, lvl_in, j_ff, j_in;
   logic               first_ff, first_in, halted_ff, halted_in;
   logic [BYTES_W-1:0] bytes_ff, bytes_in;
   status_type         res_status_ff, res_status_in;
   logic [BLOCK_W-1:0] res_block_ff, res_block_in;
   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic [BLOCK_W-1:0] rsp_block_ff;

   logic [AW-1:0] addr;
   logic          we_order, we_free, we_link, wd_free;
   logic [OW-1:0] wd_order;
   logic [LW-1:0] wd_link;
   logic          head_we;
   logic [LW-1:0] head_wd, head_rd;
   logic [OW-1:0] hidx;

   logic          out_load, req_take, fits, bud_hi, init_start;
   logic [5:0]    shamt;
   logic [CW-1:0] init_c, pg_next, bud_calc;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign out_load     = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ch.ready);

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_status_ff;
   assign rsp_ch.granted_block = rsp_block_ff;

   // Shared list-head port
   assign hidx    = (state_ff == S_SPLIT) ? j_ff : lvl_ff;
   assign head_rd = head_ff[hidx];

   // Size-to-order compare for the current candidate order
   assign shamt = 6'(ord_ff) + 6'(PAGE_SIZE_LOG2);
   assign fits  = (shamt >= 6'(BYTES_W)) ||
                  ({8'd0, bytes_ff} <= (32'd1 << shamt[4:0]));

   assign pg_next  = pg_ff + (CW'(1) << j_ff);
   assign bud_calc = pg_ff ^ (CW'(1) << rd_order_ff);
   assign bud_hi   = |(bud_ff & (CW'(1) << ord_ff));

   // Reset image of one page
   assign init_c     = CW'(init_ff);
   assign init_start = ((init_c & (TOP_C - CW'(1))) == '0) && (init_c + TOP_C <= PC_C);

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      init_in       = init_ff;
      pg_in         = pg_ff;
      bud_in        = bud_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      steps_in      = steps_ff;
      ord_in        = ord_ff;
      lvl_in        = lvl_ff;
      j_in          = j_ff;
      first_in      = first_ff;
      halted_in     = halted_ff;
      bytes_in      = bytes_ff;
      res_status_in = res_status_ff;
      res_block_in  = res_block_ff;
      addr          = pg_ff[AW-1:0];
      we_order      = 1'b0;
      we_free       = 1'b0;
      we_link       = 1'b0;
      wd_order      = '0;
      wd_free       = 1'b0;
      wd_link       = NULL_LINK;
      head_we       = 1'b0;
      head_wd       = NULL_LINK;
      case (state_ff)
         S_INIT: begin
            addr     = init_ff;
            we_order = 1'b1;
            we_free  = 1'b1;
            we_link  = 1'b1;
            wd_order = init_start ? MAX_O : '0;
            wd_free  = init_start;
            wd_link  = (init_start && (init_c + (TOP_C << 1) <= PC_C)) ?
                       LW'(init_c + TOP_C) : NULL_LINK;
            init_in  = init_ff + AW'(1);
            if (init_ff == AW'(PAGE_COUNT - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_take) begin
               res_block_in = '0;
               if (halted_ff) begin
                  res_status_in = ST_HALTED;
                  state_in      = S_DONE;
               end else if (req_ch.action == ACT_ALLOC) begin
                  bytes_in = req_ch.request_bytes;
                  ord_in   = '0;
                  state_in = S_SIZE;
               end else if (32'(req_ch.freed_block) >= 32'(PAGE_COUNT)) begin
                  res_status_in = ST_BROKEN;
                  halted_in     = 1'b1;
                  state_in      = S_DONE;
               end else begin
                  pg_in    = CW'(req_ch.freed_block);
                  first_in = 1'b1;
                  state_in = S_FPG;
               end
            end
         end
         S_SIZE: begin
            if (fits) begin
               lvl_in   = ord_ff;
               state_in = S_POP;
            end else if (ord_ff == MAX_O) begin
               res_status_in = ST_TOO_LARGE;
               halted_in     = 1'b1;
               state_in      = S_DONE;
            end else begin
               ord_in = ord_ff + OW'(1);
            end
         end
         S_POP: begin
            // Take the first nonempty list at or above the order
            if (head_rd >= NULL_LINK) begin
               if (lvl_ff == MAX_O) begin
                  res_status_in = ST_NO_MEMORY;
                  halted_in     = 1'b1;
                  state_in      = S_DONE;
               end else begin
                  lvl_in = lvl_ff + OW'(1);
               end
            end else begin
               addr     = head_rd[AW-1:0];
               pg_in    = CW'(head_rd);
               state_in = S_POPRD;
            end
         end
         S_POPRD: begin
            we_link = 1'b1;
            we_free = 1'b1;
            head_we = 1'b1;
            head_wd = rd_link_ff;
            if (lvl_ff == ord_ff) begin
               res_status_in = ST_OK;
               res_block_in  = BLOCK_W'(pg_ff);
               state_in      = S_DONE;
            end else begin
               j_in     = lvl_ff - OW'(1);
               state_in = S_SPLIT;
            end
         end
         S_SPLIT: begin
            // Hand the lower half down, keep the upper half
            we_order = 1'b1;
            we_free  = 1'b1;
            we_link  = 1'b1;
            wd_order = j_ff;
            wd_free  = 1'b1;
            head_we  = 1'b1;
            head_wd  = LW'(pg_ff);
            pg_in    = pg_next;
            if (pg_next >= PC_C) begin
               res_status_in = ST_BROKEN;
               halted_in     = 1'b1;
               state_in      = S_DONE;
            end else if (j_ff == ord_ff) begin
               state_in = S_LAST;
            end else begin
               j_in = j_ff - OW'(1);
            end
         end
         S_LAST: begin
            we_order      = 1'b1;
            we_free       = 1'b1;
            we_link       = 1'b1;
            wd_order      = ord_ff;
            res_status_in = ST_OK;
            res_block_in  = BLOCK_W'(pg_ff);
            state_in      = S_DONE;
         end
         S_FPG: begin
            state_in = S_FPGD;
         end
         S_FPGD: begin
            ord_in = rd_order_ff;
            bud_in = bud_calc;
            if (first_ff && rd_free_ff) begin
               res_status_in = ST_BROKEN;
               halted_in     = 1'b1;
               state_in      = S_DONE;
            end else if (rd_order_ff >= MAX_O) begin
               lvl_in   = MAX_O;
               state_in = S_PUSH;
            end else if (bud_calc >= PC_C) begin
               lvl_in   = rd_order_ff;
               state_in = S_PUSH;
            end else begin
               addr     = bud_calc[AW-1:0];
               lvl_in   = rd_order_ff;
               state_in = S_FBUDD;
            end
         end
         S_FBUDD: begin
            if (!rd_free_ff || (rd_order_ff != ord_ff)) begin
               state_in = S_PUSH;
            end else begin
               we_link  = 1'b1;
               we_free  = 1'b1;
               cur_in   = head_rd;
               prev_in  = NULL_LINK;
               steps_in = '0;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            // Look for the buddy on its list, bounded walk
            if ((steps_ff == NULL_LINK) || (cur_ff >= NULL_LINK)) begin
               res_status_in = ST_BROKEN;
               halted_in     = 1'b1;
               state_in      = S_DONE;
            end else begin
               addr     = cur_ff[AW-1:0];
               state_in = S_WALKD;
            end
         end
         S_WALKD: begin
            if (CW'(cur_ff) == bud_ff) begin
               if (prev_ff == NULL_LINK) begin
                  head_we = 1'b1;
                  head_wd = rd_link_ff;
               end else begin
                  addr    = prev_ff[AW-1:0];
                  we_link = 1'b1;
                  wd_link = rd_link_ff;
               end
               state_in = S_UNL;
            end else begin
               prev_in  = cur_ff;
               cur_in   = rd_link_ff;
               steps_in = steps_ff + LW'(1);
               state_in = S_WALK;
            end
         end
         S_UNL: begin
            addr     = bud_ff[AW-1:0];
            we_link  = 1'b1;
            we_free  = 1'b1;
            we_order = 1'b1;
            wd_order = bud_hi ? '0 : ord_ff + OW'(1);
            state_in = S_UNL2;
         end
         S_UNL2: begin
            we_order = 1'b1;
            wd_order = bud_hi ? ord_ff + OW'(1) : '0;
            pg_in    = bud_hi ? pg_ff : bud_ff;
            first_in = 1'b0;
            state_in = S_FPG;
         end
         S_PUSH: begin
            we_link       = 1'b1;
            we_free       = 1'b1;
            wd_link       = head_rd;
            wd_free       = 1'b1;
            head_we       = 1'b1;
            head_wd       = LW'(pg_ff);
            res_status_in = ST_OK;
            res_block_in  = '0;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Page table ports
   always_ff @(posedge clock) begin
      if (we_order) mem_order[addr] <= wd_order;
      if (we_free)  mem_free[addr]  <= wd_free;
      if (we_link)  mem_link[addr]  <= wd_link;
      rd_order_ff <= mem_order[addr];
      rd_free_ff  <= mem_free[addr];
      rd_link_ff  <= mem_link[addr];
   end

   // Control state and list heads
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_INIT;
         init_ff   <= '0;
         halted_ff <= 1'b0;
         for (int i = 0; i < MAX_ORDER; i++) begin
            head_ff[i] <= NULL_LINK;
         end
         head_ff[MAX_ORDER] <= (TOP_C <= PC_C) ? '0 : NULL_LINK;
      end else begin
         state_ff  <= state_in;
         init_ff   <= init_in;
         halted_ff <= halted_in;
         if (head_we) head_ff[hidx] <= head_wd;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      pg_ff         <= pg_in;
      bud_ff        <= bud_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      steps_ff      <= steps_in;
      ord_ff        <= ord_in;
      lvl_ff        <= lvl_in;
      j_ff          <= j_in;
      first_ff      <= first_in;
      bytes_ff      <= bytes_in;
      res_status_ff <= res_status_in;
      res_block_ff  <= res_block_in;
   end

   // Output register: hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_block_ff  <= res_block_ff;
      end
   end

   `BPA_CHECK(a_halt_sticky, halted_ff |=> halted_ff, "halt flag dropped")
   `BPA_CHECK(a_err_no_block, rsp_valid_ff && (rsp_status_ff != ST_OK) |-> rsp_block_ff == '0, "error carries a block")
   `BPA_CHECK(a_err_halts, out_load && (res_status_ff != ST_OK) |=> halted_ff, "error left block running")
   `BPA_CHECK_ALWAYS(a_init_closed, (state_ff == S_INIT) |-> !req_ch.ready, "request taken during clearing pass")

endmodule
